// File: hdl/tccbc_pkg.sv
package tccbc_pkg;

  // Output mode codes
  localparam logic [1:0] MODE_STANDBY     = 2'd0;
  localparam logic [1:0] MODE_CHARGING    = 2'd1;
  localparam logic [1:0] MODE_DISCHARGING = 2'd2;

  // Full indicator codes
  localparam logic [1:0] FULL_OFF   = 2'd0;
  localparam logic [1:0] FULL_ON    = 2'd1;
  localparam logic [1:0] FULL_BLINK = 2'd2;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_CHARGE_VOLTAGE = 2'd0;
  localparam logic [1:0] REG_CHARGE_CURRENT = 2'd1;
  localparam logic [1:0] REG_OVERVOLTAGE    = 2'd2;
  localparam logic [1:0] REG_LOW_CELL       = 2'd3;

  // Register reset values
  localparam logic [13:0] CHARGE_VOLTAGE_RST = 14'd12600;
  localparam logic [12:0] CHARGE_CURRENT_RST = 13'd2000;
  localparam logic [12:0] OVERVOLTAGE_RST    = 13'd4200;
  localparam logic [12:0] LOW_CELL_RST       = 13'd2800;

  // Charge control limits, mV / mA
  localparam logic [12:0]        LO_START        = 13'd5000;
  localparam logic [12:0]        HI_BALANCE_MIN  = 13'd4000;
  localparam logic [12:0]        SPREAD_BALANCE  = 13'd10;
  localparam logic [12:0]        SPREAD_CLEAR    = 13'd20;
  localparam logic [12:0]        EOC_MARGIN      = 13'd50;
  localparam logic [13:0]        RECHARGE_MARGIN = 14'd100;
  localparam logic [12:0]        OVT_SET_MARGIN  = 13'd10;
  localparam logic [12:0]        OVT_CLR_MARGIN  = 13'd40;
  localparam logic signed [15:0] TERM_CURRENT    = 16'sd400;
  localparam logic signed [15:0] DISCHARGE_LIMIT = -16'sd1;

  // Pack level bar marks, mV
  localparam int LEVEL_STEPS = 7;
  localparam logic [13:0] LEVEL_MARKS [LEVEL_STEPS] = '{
    14'd12300, 14'd11400, 14'd10950, 14'd10350, 14'd9900, 14'd9450, 14'd9000
  };

  typedef enum logic [2:0] {
    ST_STANDBY     = 3'b001,
    ST_CHARGING    = 3'b010,
    ST_DISCHARGING = 3'b100
  } mode_state_t;

  typedef struct packed {
    mode_state_t mode;
    logic        charger_on;
    logic        reduced;
    logic [1:0]  balance;
  } state_t;

  typedef struct packed {
    logic [13:0] charge_voltage;
    logic [12:0] charge_current;
    logic [12:0] overvoltage;
    logic [12:0] low_cell;
  } cfg_t;

  typedef struct packed {
    logic [12:0]        cell_one_mv;
    logic [12:0]        cell_two_mv;
    logic [12:0]        cell_three_mv;
    logic [13:0]        pack_mv;
    logic signed [15:0] pack_current_ma;
    logic               charger_pin_high;
    logic               show_status;
  } item_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       charger_enable;
    logic [1:0] balance_cell;
    logic       reduce_current;
    logic       low_power_request;
    logic       watchdog_kick;
    logic       charge_leds_on;
    logic [1:0] full_led;
    logic [2:0] low_cell_blink;
    logic [2:0] level_bar;
    logic       level_shown;
  } result_t;

endpackage

// File: hdl/three_cell_charge_balance_controller.sv
// Three-cell charge balance controller. Each input word is one periodic
// tick carrying the three cell voltages, pack voltage, signed pack current,
// the charger-present pin (active low) and the level-display request; each
// tick yields exactly one result word with the next mode, charger enable,
// balance cell, reduced-current request, the low-power and watchdog pulses,
// the LED indications and the 0..7 level bar. An accepted word passes the
// input register, then the result register, and a new word is taken every
// cycle while in_stall is low: the whole tick evaluation is one pass of
// compare logic between the two registers, and the controller state
// updates as a word moves into the result register. in_stall rises
// only when the result register is full and stalled. Thresholds are written
// over the APB port at 0x0 (charge voltage, 14 b), 0x4 (charge current, 13 b),
// 0x8 (cell overvoltage, 13 b) and 0xC (low cell, 13 b); write them only
// while no tick is in flight. Reads return the stored values.
module three_cell_charge_balance_controller (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [12:0]        cell_one_mv,
  input  logic [12:0]        cell_two_mv,
  input  logic [12:0]        cell_three_mv,
  input  logic [13:0]        pack_mv,
  input  logic signed [15:0] pack_current_ma,
  input  logic               charger_pin_high,
  input  logic               show_status,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         mode,
  output logic               charger_enable,
  output logic [1:0]         balance_cell,
  output logic               reduce_current,
  output logic               low_power_request,
  output logic               watchdog_kick,
  output logic               charge_leds_on,
  output logic [1:0]         full_led,
  output logic [2:0]         low_cell_blink,
  output logic [2:0]         level_bar,
  output logic               level_shown,
  // config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  tccbc_pkg::cfg_t    cfg;
  tccbc_pkg::state_t  state;
  tccbc_pkg::state_t  state_next;
  tccbc_pkg::item_t   s1_item;
  tccbc_pkg::result_t step_result;
  tccbc_pkg::result_t res;
  logic               s1_valid;
  logic               s1_adv;
  logic               in_take;
  logic               cfg_wr;

  // ---------------- config registers ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.charge_voltage <= tccbc_pkg::CHARGE_VOLTAGE_RST;
      cfg.charge_current <= tccbc_pkg::CHARGE_CURRENT_RST;
      cfg.overvoltage    <= tccbc_pkg::OVERVOLTAGE_RST;
      cfg.low_cell       <= tccbc_pkg::LOW_CELL_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        tccbc_pkg::REG_CHARGE_VOLTAGE: cfg.charge_voltage <= pwdata[13:0];
        tccbc_pkg::REG_CHARGE_CURRENT: cfg.charge_current <= pwdata[12:0];
        tccbc_pkg::REG_OVERVOLTAGE:    cfg.overvoltage    <= pwdata[12:0];
        tccbc_pkg::REG_LOW_CELL:       cfg.low_cell       <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      tccbc_pkg::REG_CHARGE_VOLTAGE: prdata = 32'(cfg.charge_voltage);
      tccbc_pkg::REG_CHARGE_CURRENT: prdata = 32'(cfg.charge_current);
      tccbc_pkg::REG_OVERVOLTAGE:    prdata = 32'(cfg.overvoltage);
      tccbc_pkg::REG_LOW_CELL:       prdata = 32'(cfg.low_cell);
      default:                       prdata = '0;
    endcase
  end

  // ---------------- handshake ----------------
  // the input register drains whenever the result register is free or being read
  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item.cell_one_mv      <= cell_one_mv;
      s1_item.cell_two_mv      <= cell_two_mv;
      s1_item.cell_three_mv    <= cell_three_mv;
      s1_item.pack_mv          <= pack_mv;
      s1_item.pack_current_ma  <= pack_current_ma;
      s1_item.charger_pin_high <= charger_pin_high;
      s1_item.show_status      <= show_status;
    end
  end

  // ---------------- tick evaluation ----------------
  tccbc_step u_step (
    .state      (state),
    .cfg        (cfg),
    .item       (s1_item),
    .state_next (state_next),
    .result     (step_result)
  );

  // controller state commits when its word enters the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode       <= tccbc_pkg::ST_STANDBY;
      state.charger_on <= 1'b0;
      state.reduced    <= 1'b0;
      state.balance    <= '0;
    end else if (s1_adv) begin
      state <= state_next;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res <= step_result;
    end
  end

  assign mode              = res.mode;
  assign charger_enable    = res.charger_enable;
  assign balance_cell      = res.balance_cell;
  assign reduce_current    = res.reduce_current;
  assign low_power_request = res.low_power_request;
  assign watchdog_kick     = res.watchdog_kick;
  assign charge_leds_on    = res.charge_leds_on;
  assign full_led          = res.full_led;
  assign low_cell_blink    = res.low_cell_blink;
  assign level_bar         = res.level_bar;
  assign level_shown       = res.level_shown;

  // ---------------- checks ----------------
  // charger can only be held on while the controller sits in charging
  a_charger_in_charging: assert property (@(posedge clk) disable iff (rst)
    state.charger_on |-> state.mode == tccbc_pkg::ST_CHARGING)
    else $error("charger on outside charging mode");

  // a balance cell is only selected with the charger running
  a_balance_needs_charger: assert property (@(posedge clk) disable iff (rst)
    state.balance != 2'd0 |-> state.charger_on)
    else $error("balancing without charger");

  // a word leaving the input register always lands in the result register
  a_advance_lands: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> out_valid)
    else $error("advanced word lost");

  // the unused mode code never shows up on a result
  a_mode_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> mode != 2'd3)
    else $error("illegal mode code on result");

endmodule

// File: hdl/tccbc_step.sv
module tccbc_step (
  input  tccbc_pkg::state_t  state,
  input  tccbc_pkg::cfg_t    cfg,
  input  tccbc_pkg::item_t   item,
  output tccbc_pkg::state_t  state_next,
  output tccbc_pkg::result_t result
);

  logic [12:0] cells [3];
  logic [12:0] hi;
  logic [12:0] lo;
  logic [1:0]  hi_idx;
  logic [12:0] spread;
  logic [14:0] hi_x3;
  logic [14:0] hi_m_x3;
  logic        above_eoc;
  logic        near_eoc;
  logic signed [16:0] cur_p1;
  logic signed [20:0] cur_p1_x10;
  logic        below_taper;
  logic [2:0]  level;
  tccbc_pkg::mode_state_t mode_new;

  assign cells[0] = item.cell_one_mv;
  assign cells[1] = item.cell_two_mv;
  assign cells[2] = item.cell_three_mv;

  // highest cell (lowest index wins ties), lowest cell clamped at start value
  always_comb begin
    hi     = '0;
    hi_idx = '0;
    lo     = tccbc_pkg::LO_START;
    for (int i = 0; i < 3; i++) begin
      if (cells[i] > hi) begin
        hi     = cells[i];
        hi_idx = 2'(i + 1);
      end
      if (cells[i] < lo) begin
        lo = cells[i];
      end
    end
  end

  assign spread = hi - lo;

  // hi > floor(V/3) <=> 3*hi > V; same with the 50 mV margin folded into hi
  assign hi_x3     = 15'(hi) * 15'd3;
  assign hi_m_x3   = (15'(hi) + 15'(tccbc_pkg::EOC_MARGIN)) * 15'd3;
  assign above_eoc = hi_x3 > 15'(cfg.charge_voltage);
  assign near_eoc  = hi_m_x3 > 15'(cfg.charge_voltage);

  // cur < floor(I/10) <=> 10*(cur+1) <= I
  assign cur_p1      = 17'(item.pack_current_ma) + 17'sd1;
  assign cur_p1_x10  = 21'(cur_p1) * 21'sd10;
  assign below_taper = cur_p1_x10 <= $signed({8'd0, cfg.charge_current});

  always_comb begin
    level = '0;
    for (int k = 0; k < tccbc_pkg::LEVEL_STEPS; k++) begin
      level = level + 3'(item.pack_mv > tccbc_pkg::LEVEL_MARKS[k]);
    end
  end

  always_comb begin
    state_next               = state;
    result                   = '0;
    result.full_led          = tccbc_pkg::FULL_OFF;

    unique case (state.mode)
      tccbc_pkg::ST_CHARGING: begin
        if (state.charger_on) begin
          if ((below_taper || item.pack_current_ma < tccbc_pkg::TERM_CURRENT)
              && near_eoc) begin
            state_next.charger_on = 1'b0;
            state_next.balance    = '0;
          end else begin
            result.charge_leds_on = 1'b1;
            result.full_led       = tccbc_pkg::FULL_BLINK;
            if (above_eoc || (hi > tccbc_pkg::HI_BALANCE_MIN &&
                              spread > tccbc_pkg::SPREAD_BALANCE)) begin
              state_next.balance = hi_idx;
            end else begin
              state_next.balance = '0;
            end
            if (14'(hi) + 14'(tccbc_pkg::OVT_SET_MARGIN) > 14'(cfg.overvoltage)) begin
              state_next.reduced = 1'b1;
            end else if ((14'(hi) + 14'(tccbc_pkg::OVT_CLR_MARGIN) < 14'(cfg.overvoltage)
                          && spread < tccbc_pkg::SPREAD_CLEAR)
                         || hi < tccbc_pkg::HI_BALANCE_MIN) begin
              state_next.reduced = 1'b0;
            end
          end
        end else if (15'(item.pack_mv) + 15'(tccbc_pkg::RECHARGE_MARGIN)
                     < 15'(cfg.charge_voltage)) begin
          result.low_power_request = 1'b1;
          state_next.charger_on    = 1'b1;
        end else begin
          result.full_led       = tccbc_pkg::FULL_ON;
          state_next.charger_on = 1'b0;
          state_next.balance    = '0;
        end
        result.watchdog_kick = 1'b1;
      end
      tccbc_pkg::ST_DISCHARGING: begin
        for (int i = 0; i < 3; i++) begin
          result.low_cell_blink[i] = cells[i] < cfg.low_cell;
        end
      end
      default: ;
    endcase

    // mode selection; leaving a mode without the charger shuts it down
    if (!item.charger_pin_high) begin
      mode_new = tccbc_pkg::ST_CHARGING;
    end else begin
      mode_new = (item.pack_current_ma < tccbc_pkg::DISCHARGE_LIMIT) ?
                 tccbc_pkg::ST_DISCHARGING : tccbc_pkg::ST_STANDBY;
      if (state.mode != mode_new) begin
        state_next.balance       = '0;
        state_next.charger_on    = 1'b0;
        result.low_power_request = 1'b1;
        result.watchdog_kick     = 1'b1;
      end
    end
    state_next.mode = mode_new;

    unique case (mode_new)
      tccbc_pkg::ST_CHARGING:    result.mode = tccbc_pkg::MODE_CHARGING;
      tccbc_pkg::ST_DISCHARGING: result.mode = tccbc_pkg::MODE_DISCHARGING;
      default:                   result.mode = tccbc_pkg::MODE_STANDBY;
    endcase

    result.charger_enable = state_next.charger_on;
    result.balance_cell   = state_next.balance;
    result.reduce_current = state_next.reduced;
    result.level_bar      = item.show_status ? level : 3'd0;
    result.level_shown    = item.show_status;
  end

endmodule

// File: tb/three_cell_charge_balance_controller_tb.sv
module three_cell_charge_balance_controller_tb;

  // cycles with no word moving on either channel before the run is declared hung
  localparam int STUCK_LIMIT = 2000;
  // long receiver hold-off, long enough to back the block up into in_stall
  localparam int HOLD_CYCLES = 120;
  // input register plus result register, with some margin
  localparam int DRAIN_CYCLES = 4;
  localparam int ITEM_W = $bits(tccbc_pkg::item_t);

  typedef enum {RUN_CHARGE, RUN_DISCHARGE, RUN_STANDBY, RUN_NOISE} run_kind_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [12:0]        cell_one_mv = '0;
  logic [12:0]        cell_two_mv = '0;
  logic [12:0]        cell_three_mv = '0;
  logic [13:0]        pack_mv = '0;
  logic signed [15:0] pack_current_ma = '0;
  logic               charger_pin_high = 1'b1;
  logic               show_status = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         mode;
  logic               charger_enable;
  logic [1:0]         balance_cell;
  logic               reduce_current;
  logic               low_power_request;
  logic               watchdog_kick;
  logic               charge_leds_on;
  logic [1:0]         full_led;
  logic [2:0]         low_cell_blink;
  logic [2:0]         level_bar;
  logic               level_shown;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  three_cell_charge_balance_controller i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cell_one_mv(cell_one_mv), .cell_two_mv(cell_two_mv), .cell_three_mv(cell_three_mv),
    .pack_mv(pack_mv), .pack_current_ma(pack_current_ma),
    .charger_pin_high(charger_pin_high), .show_status(show_status),
    .out_valid(out_valid), .out_stall(out_stall),
    .mode(mode), .charger_enable(charger_enable), .balance_cell(balance_cell),
    .reduce_current(reduce_current), .low_power_request(low_power_request),
    .watchdog_kick(watchdog_kick), .charge_leds_on(charge_leds_on), .full_led(full_led),
    .low_cell_blink(low_cell_blink), .level_bar(level_bar), .level_shown(level_shown),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // Shadow of the threshold registers, kept in step with every bus write.
  logic [13:0] cv_q  = tccbc_pkg::CHARGE_VOLTAGE_RST;
  logic [12:0] cc_q  = tccbc_pkg::CHARGE_CURRENT_RST;
  logic [12:0] ovt_q = tccbc_pkg::OVERVOLTAGE_RST;
  logic [12:0] lct_q = tccbc_pkg::LOW_CELL_RST;

  // Shadow of the controller state, advanced once per accepted input word.
  logic [1:0] mode_q   = tccbc_pkg::MODE_STANDBY;
  logic       chg_on_q = 1'b0;
  logic       red_q    = 1'b0;
  logic [1:0] bal_q    = 2'd0;

  tccbc_pkg::item_t   tick_backlog[$];   // ticks waiting to be driven
  tccbc_pkg::result_t due_outcomes[$];   // predicted result words, oldest first
  tccbc_pkg::item_t   in_word;           // tick currently on the input ports
  tccbc_pkg::result_t seen_word, want_word;

  int send_idle_pct = 38;
  int recv_idle_pct = 51;
  int errors = 0;
  int results_seen = 0;
  int hold_left = 0;
  int stuck_cycles = 0;

  // One controller tick: act on the current mode, then pick the next mode
  // from the charger pin and current. Updates the shadow state.
  function automatic tccbc_pkg::result_t controller_tick(input tccbc_pkg::item_t t);
    tccbc_pkg::result_t r;
    int         c[3];
    int         pack, cur, hi, lo, spread, eoc, taper, ovt, bars, k;
    logic [1:0] hi_idx, nxt;
    r = '0;
    c[0] = int'(t.cell_one_mv);
    c[1] = int'(t.cell_two_mv);
    c[2] = int'(t.cell_three_mv);
    pack = int'(t.pack_mv);
    cur = int'(t.pack_current_ma);
    ovt = int'(ovt_q);
    if (mode_q == tccbc_pkg::MODE_CHARGING) begin
      hi = 0;
      lo = int'(tccbc_pkg::LO_START);
      hi_idx = 2'd0;
      eoc = int'(cv_q) / 3;
      // strict compare: first of equal maxima wins, all-zero cells pick none
      for (k = 0; k < 3; k++) begin
        if (c[k] > hi) begin
          hi = c[k];
          hi_idx = 2'(k + 1);
        end
        if (c[k] < lo) lo = c[k];
      end
      spread = hi - lo;
      if (chg_on_q) begin
        taper = int'(cc_q) / 10;
        if ((cur < taper || cur < int'(tccbc_pkg::TERM_CURRENT)) &&
            hi > eoc - int'(tccbc_pkg::EOC_MARGIN)) begin
          // pack full: charger off, stop balancing
          chg_on_q = 1'b0;
          bal_q = 2'd0;
        end else begin
          r.charge_leds_on = 1'b1;
          r.full_led = tccbc_pkg::FULL_BLINK;
          if (hi > eoc || (hi > int'(tccbc_pkg::HI_BALANCE_MIN) &&
                           spread > int'(tccbc_pkg::SPREAD_BALANCE)))
            bal_q = hi_idx;
          else
            bal_q = 2'd0;
          // hysteresis: flag holds between the set and clear conditions
          if (hi > ovt - int'(tccbc_pkg::OVT_SET_MARGIN))
            red_q = 1'b1;
          else if ((hi < ovt - int'(tccbc_pkg::OVT_CLR_MARGIN) &&
                    spread < int'(tccbc_pkg::SPREAD_CLEAR)) ||
                   hi < int'(tccbc_pkg::HI_BALANCE_MIN))
            red_q = 1'b0;
        end
      end else if (pack < int'(cv_q) - int'(tccbc_pkg::RECHARGE_MARGIN)) begin
        r.low_power_request = 1'b1;
        chg_on_q = 1'b1;
      end else begin
        r.full_led = tccbc_pkg::FULL_ON;
        chg_on_q = 1'b0;
        bal_q = 2'd0;
      end
      r.watchdog_kick = 1'b1;
    end else if (mode_q == tccbc_pkg::MODE_DISCHARGING) begin
      for (k = 0; k < 3; k++)
        if (c[k] < int'(lct_q)) r.low_cell_blink[k] = 1'b1;
    end
    if (!t.charger_pin_high) begin
      nxt = tccbc_pkg::MODE_CHARGING;
    end else begin
      nxt = (cur < int'(tccbc_pkg::DISCHARGE_LIMIT)) ? tccbc_pkg::MODE_DISCHARGING :
                                                       tccbc_pkg::MODE_STANDBY;
      // any change of mode without the charger shuts it down
      if (mode_q != nxt) begin
        bal_q = 2'd0;
        chg_on_q = 1'b0;
        r.low_power_request = 1'b1;
        r.watchdog_kick = 1'b1;
      end
    end
    mode_q = nxt;
    r.mode = nxt;
    r.charger_enable = chg_on_q;
    r.balance_cell = bal_q;
    r.reduce_current = red_q;
    bars = 0;
    if (t.show_status)
      for (k = 0; k < tccbc_pkg::LEVEL_STEPS; k++)
        if (pack > int'(tccbc_pkg::LEVEL_MARKS[k])) bars++;
    r.level_bar = 3'(bars);
    r.level_shown = t.show_status;
    return r;
  endfunction

  function automatic string describe(input tccbc_pkg::result_t r);
    return {$sformatf("mode=%0d en=%0d bal=%0d red=%0d lp=%0d wd=%0d ",
                      r.mode, r.charger_enable, r.balance_cell, r.reduce_current,
                      r.low_power_request, r.watchdog_kick),
            $sformatf("leds=%0d full=%0d blink=%0d bar=%0d shown=%0d",
                      r.charge_leds_on, r.full_led, r.low_cell_blink, r.level_bar,
                      r.level_shown)};
  endfunction

  task automatic report_mismatch(input string what, input string exp_s, input string act_s);
    errors++;
    if (errors <= 10) begin
      $display("%s mismatch at %0t", what, $realtime);
      $display("  expected %s", exp_s);
      $display("  actual   %s", act_s);
    end
  endtask

  // Driver: a new word goes out when the port is empty or the last word moved.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) due_outcomes.push_back(controller_tick(in_word));
      if (!in_valid || !in_stall) begin
        if (tick_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_word = tick_backlog.pop_front();
          in_valid <= 1'b1;
          cell_one_mv <= in_word.cell_one_mv;
          cell_two_mv <= in_word.cell_two_mv;
          cell_three_mv <= in_word.cell_three_mv;
          pack_mv <= in_word.pack_mv;
          pack_current_ma <= in_word.pack_current_ma;
          charger_pin_high <= in_word.charger_pin_high;
          show_status <= in_word.show_status;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result word, and owns the receiver stall, including
  // the long hold-offs that fill the block up.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        seen_word = {mode, charger_enable, balance_cell, reduce_current, low_power_request,
                     watchdog_kick, charge_leds_on, full_led, low_cell_blink, level_bar,
                     level_shown};
        if (due_outcomes.size() == 0) begin
          report_mismatch("unexpected result", "nothing", describe(seen_word));
        end else begin
          want_word = due_outcomes.pop_front();
          if (seen_word !== want_word)
            report_mismatch("result", describe(want_word), describe(seen_word));
        end
        results_seen++;
        if (results_seen == 150 || results_seen == 900) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Hang detection: nothing accepted on either side for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("[three_cell_charge_balance_controller] ERROR");
    $finish;
  end

  // Bus write with setup and access phases, then a read back of the same
  // register. The shadow takes the value at the register's width.
  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] stored;
    case (idx)
      tccbc_pkg::REG_CHARGE_VOLTAGE: begin
        cv_q = value[13:0];
        stored = 32'(cv_q);
      end
      tccbc_pkg::REG_CHARGE_CURRENT: begin
        cc_q = value[12:0];
        stored = 32'(cc_q);
      end
      tccbc_pkg::REG_OVERVOLTAGE: begin
        ovt_q = value[12:0];
        stored = 32'(ovt_q);
      end
      default: begin
        lct_q = value[12:0];
        stored = 32'(lct_q);
      end
    endcase
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    // read back: psel stays up, a fresh setup phase
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== stored)
      report_mismatch($sformatf("register %0d read back", idx),
                      $sformatf("%0d", stored), $sformatf("%0d", prdata));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Block is idle once every tick went in and every result came out.
  task automatic wait_drained();
    @(negedge clk);
    while (tick_backlog.size() != 0 || in_valid || due_outcomes.size() != 0)
      @(negedge clk);
  endtask

  task automatic add_tick(input int c1, input int c2, input int c3, input int pack,
                          input int cur, input logic pin, input logic show);
    tccbc_pkg::item_t t;
    t.cell_one_mv = 13'(c1);
    t.cell_two_mv = 13'(c2);
    t.cell_three_mv = 13'(c3);
    t.pack_mv = 14'(pack);
    t.pack_current_ma = 16'(cur);
    t.charger_pin_high = pin;
    t.show_status = show;
    tick_backlog.push_back(t);
  endtask

  function automatic int near(input int center, input int span, input int top);
    int v;
    v = center - span + int'($urandom_range(2 * span));
    if (v < 0) v = 0;
    if (v > top) v = top;
    return v;
  endfunction

  // Tick shaped by the kind of run it belongs to; noise keeps all bits random.
  function automatic tccbc_pkg::item_t random_tick(input run_kind_t kind);
    tccbc_pkg::item_t t;
    int    base, span, pick;
    t = ITEM_W'({$urandom, $urandom, $urandom});
    case (kind)
      RUN_CHARGE: begin
        t.charger_pin_high = ($urandom_range(24) == 0);
        pick = $urandom_range(4);
        base = (pick == 0) ? int'(cv_q) / 3 :
               (pick == 1) ? int'(ovt_q) :
               (pick == 2) ? 4000 :
               (pick == 3) ? 4150 : 5100;
        span = $urandom_range(1) ? 8 : 60;
        t.cell_one_mv = 13'(near(base, span, 8191));
        t.cell_two_mv = 13'(near(base, span, 8191));
        t.cell_three_mv = 13'(near(base, span, 8191));
        pick = $urandom_range(3);
        t.pack_current_ma = 16'((pick == 0) ? near(int'(cc_q) / 10, 20, 32767) :
                                (pick == 1) ? near(400, 20, 32767) :
                                (pick == 2) ? int'($urandom_range(3000)) : int'($urandom));
        t.pack_mv = 14'($urandom_range(1) ? near(int'(cv_q) - 100, 40, 16383) :
                                            near(3 * base, 600, 16383));
      end
      RUN_DISCHARGE: begin
        t.charger_pin_high = 1'b1;
        t.pack_current_ma = 16'(($urandom_range(7) == 0) ? -int'($urandom_range(2)) :
                                                           -near(3000, 2999, 32767));
        t.cell_one_mv = 13'(near(int'(lct_q), 150, 8191));
        t.cell_two_mv = 13'(near(int'(lct_q), 150, 8191));
        t.cell_three_mv = 13'(near(int'(lct_q), 150, 8191));
        t.pack_mv = 14'(near(10000, 3500, 16383));
      end
      RUN_STANDBY: begin
        t.charger_pin_high = 1'b1;
        t.pack_current_ma = 16'(($urandom_range(3) == 0) ? -1 : int'($urandom_range(2000)));
        t.pack_mv = 14'(near(10500, 2500, 16383));
      end
      default: ;
    endcase
    if (kind != RUN_NOISE) t.show_status = ($urandom_range(3) == 0);
    return t;
  endfunction

  // Random part: mostly runs of charge or discharge ticks so the charger
  // actually turns on, with standby runs and pure noise mixed in.
  task automatic queue_random_ticks(input int count);
    int        left, len, roll, k;
    run_kind_t kind;
    left = count;
    while (left > 0) begin
      roll = $urandom_range(99);
      kind = (roll < 55) ? RUN_CHARGE :
             (roll < 75) ? RUN_DISCHARGE :
             (roll < 88) ? RUN_STANDBY : RUN_NOISE;
      len = $urandom_range(16, 3);
      if (len > left) len = left;
      for (k = 0; k < len; k++) tick_backlog.push_back(random_tick(kind));
      left -= len;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed ticks at reset thresholds: eoc 4200, full above 4150,
    // reduce set above 4190 and cleared below 4160.
    add_tick(0, 0, 0, 0, 0, 1'b1, 1'b1);                 // standby, empty bar
    add_tick(1000, 1000, 1000, 9001, -1, 1'b1, 1'b1);    // -1 mA is not discharging
    add_tick(3000, 3000, 3000, 16383, -2, 1'b1, 1'b1);   // to discharging, full bar
    add_tick(2799, 2800, 0, 12000, -32768, 1'b1, 1'b0);  // low cells one and three
    add_tick(8191, 8191, 8191, 11000, -500, 1'b1, 1'b1);
    add_tick(3900, 3900, 3900, 11700, 32767, 1'b0, 1'b0); // charger present
    add_tick(3900, 3950, 3900, 12499, 1500, 1'b0, 1'b0);  // charger turns on
    add_tick(4150, 4100, 4000, 12400, 1000, 1'b0, 1'b0);  // balance on spread
    add_tick(4195, 4195, 4190, 12500, 1000, 1'b0, 1'b1);  // tie, reduce set
    add_tick(4170, 4175, 4180, 12500, 1000, 1'b0, 1'b0);  // reduce held
    add_tick(4100, 4105, 4100, 12300, 1000, 1'b0, 1'b0);  // reduce cleared
    add_tick(6000, 6000, 6000, 16383, 1000, 1'b0, 1'b1);  // cells above lowest-start
    add_tick(0, 0, 0, 0, 1000, 1'b0, 1'b0);               // no cell selected
    add_tick(4160, 4160, 4160, 12480, 399, 1'b0, 1'b0);   // end of charge
    add_tick(4160, 4160, 4160, 12500, 0, 1'b0, 1'b0);     // charged, full on
    add_tick(3700, 3700, 3700, 11100, 0, 1'b0, 1'b0);     // recharge
    add_tick(4100, 4100, 4100, 12300, 0, 1'b1, 1'b0);     // unplug: shut down
    add_tick(3700, 3700, 3700, 11100, 5, 1'b1, 1'b1);
    add_tick(3700, 3700, 3700, 11100, 5, 1'b0, 1'b0);
    add_tick(3700, 3700, 3700, 0, 5, 1'b0, 1'b0);
    add_tick(4000, 4000, 4000, 12000, -100, 1'b1, 1'b0);  // charging straight to discharge
    add_tick(2000, 2000, 2000, 6000, -100, 1'b0, 1'b1);   // all cells low
    add_tick(8191, 0, 8191, 16383, 32767, 1'b0, 1'b1);
    add_tick(0, 8191, 8191, 0, -32768, 1'b1, 1'b1);
    queue_random_ticks(350);
    wait_drained();

    send_idle_pct = 51;
    recv_idle_pct = 38;
    write_register(tccbc_pkg::REG_CHARGE_VOLTAGE, 32'hFFFF_FFFF);
    write_register(tccbc_pkg::REG_CHARGE_CURRENT, 32'hFFFF_FFFF);
    write_register(tccbc_pkg::REG_OVERVOLTAGE, 32'hFFFF_FFFF);
    write_register(tccbc_pkg::REG_LOW_CELL, 32'hFFFF_FFFF);
    queue_random_ticks(300);
    wait_drained();

    write_register(tccbc_pkg::REG_CHARGE_VOLTAGE, 32'd0);
    write_register(tccbc_pkg::REG_CHARGE_CURRENT, 32'd0);
    write_register(tccbc_pkg::REG_OVERVOLTAGE, 32'd0);
    write_register(tccbc_pkg::REG_LOW_CELL, 32'd0);
    queue_random_ticks(300);
    wait_drained();

    // plausible pack settings, no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_register(tccbc_pkg::REG_CHARGE_VOLTAGE, $urandom_range(13000, 11000));
    write_register(tccbc_pkg::REG_CHARGE_CURRENT, $urandom_range(4000, 500));
    write_register(tccbc_pkg::REG_OVERVOLTAGE, $urandom_range(4300, 4000));
    write_register(tccbc_pkg::REG_LOW_CELL, $urandom_range(3300, 2500));
    queue_random_ticks(350);
    wait_drained();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0)
      $display("[three_cell_charge_balance_controller] OK");
    else
      $display("[three_cell_charge_balance_controller] ERROR");
    $finish;
  end

endmodule

// File: filelist.f
hdl/tccbc_pkg.sv
hdl/tccbc_step.sv
hdl/three_cell_charge_balance_controller.sv
tb/three_cell_charge_balance_controller_tb.sv
